>>> src/ksc_pkg.sv
// ----------------------------------------------------------------------------
// ksc_pkg
// shared types, codes and the segment decoder for the knob steered counter
// ----------------------------------------------------------------------------
package ksc_pkg;

  localparam int unsigned BCD_CELLS  = 4;
  localparam int unsigned COUNT_W    = 14;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned SEL_W      = 4;
  localparam int unsigned ADC_W      = 10;
  localparam int unsigned THR_W      = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = 14'd9999;
  localparam logic [COUNT_W-1:0] COUNT_RESET     = 14'd255;
  // same reset count, one decimal digit per nibble, ones digit lowest
  localparam logic [4*BCD_CELLS-1:0] COUNT_RESET_BCD = 16'h0255;

  localparam logic [THR_W-1:0] LOW_RESET  = 8'd85;
  localparam logic [THR_W-1:0] HIGH_RESET = 8'd170;

  // configuration register indexes
  localparam logic REG_LOW  = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  // item kinds
  localparam logic ACT_SCAN  = 1'b0;
  localparam logic ACT_COUNT = 1'b1;

  // count direction codes
  localparam logic [1:0] DIR_HOLD = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef logic [3:0] bcd_t;

  // step request passed along the digit chain
  typedef struct packed {
    logic up;
    logic down;
  } step_t;

  function automatic logic [SEG_W-1:0] seg_encode(input bcd_t d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

>>> src/ksc_bcd_cell.sv
// ----------------------------------------------------------------------------
// ksc_bcd_cell
// one decimal digit of the count, passes carry or borrow to the next digit
// ----------------------------------------------------------------------------
module ksc_bcd_cell import ksc_pkg::*; #(
  parameter logic [3:0] RESET_DIGIT = 4'd0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  step_t step_in,
  output step_t step_out,
  output bcd_t  digit
);

  bcd_t digit_r, digit_nxt;

  always_comb begin
    digit_nxt = digit_r;
    if (step_in.up) begin
      digit_nxt = (digit_r == 4'd9) ? 4'd0 : digit_r + 4'd1;
    end else if (step_in.down) begin
      digit_nxt = (digit_r == 4'd0) ? 4'd9 : digit_r - 4'd1;
    end
  end

  assign step_out.up   = step_in.up   && (digit_r == 4'd9);
  assign step_out.down = step_in.down && (digit_r == 4'd0);
  assign digit         = digit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= RESET_DIGIT;
    end else begin
      digit_r <= digit_nxt;
    end
  end

endmodule

>>> src/knob_steered_counter_with_led_scan_top.sv
// ----------------------------------------------------------------------------
// knob_steered_counter_with_led_scan_top
// decimal up/down counter with multiplexed seven-segment scan and knob steering
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one word per event: a scan
//   tick (in_action = 0) with a 10-bit knob level, or a count edge
//   (in_action = 1). every accepted word gives exactly one result word on
//   the output channel (out_valid/out_ready): latched segment pattern, one-hot
//   digit enable and the count after the event.
//   out_valid rises in the cycle after acceptance. one word per cycle is
//   sustained; the output register decouples the two sides, so in_ready only
//   drops while a result sits unread and out_ready is low.
//   the count lives in a chain of four decimal digit cells; a count edge
//   ripples its carry or borrow through the chain in the same cycle, and a
//   binary copy of the count is kept for saturation and the count output.
//   cfg_we writes low_threshold (index 0) or high_threshold (index 1) at once.
//   reset (rst_n low, synchronous) empties the output register, sets the count
//   to 255, direction to hold, the scan before the first digit, latches to 0
//   and thresholds to 85 and 170.
// ----------------------------------------------------------------------------
module knob_steered_counter_with_led_scan_top import ksc_pkg::*; #(
  parameter int unsigned DIGITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [ADC_W-1:0]   in_adc_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SEG_W-1:0]   out_segments,
  output logic [SEL_W-1:0]   out_digit_select,
  output logic [COUNT_W-1:0] out_count_value,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [THR_W-1:0]   cfg_data
);

  localparam int unsigned POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic               accept;
  logic               is_scan;
  logic               is_count;

  logic [THR_W-1:0]   low_r, high_r;
  logic [1:0]         dir_r, dir_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W:0]     place;
  logic [3:0]         pos_ext;
  logic [SEG_W-1:0]   seg_r, seg_nxt;
  logic [SEL_W-1:0]   sel_r, sel_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r;
  logic [THR_W-1:0]   level;
  bcd_t               cur_digit;

  step_t              chain [0:BCD_CELLS];
  bcd_t               digits [0:BCD_CELLS-1];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_scan  = accept && (in_action == ACT_SCAN);
  assign is_count = accept && (in_action == ACT_COUNT);

  // step request entering the ones digit, saturated at both ends
  assign chain[0].up   = is_count && (dir_r == DIR_UP)   && (count_r != COUNT_MAX);
  assign chain[0].down = is_count && (dir_r == DIR_DOWN) && (count_r != '0);

  for (genvar i = 0; i < BCD_CELLS; i++) begin : g_cell
    ksc_bcd_cell #(
      .RESET_DIGIT (COUNT_RESET_BCD[4*i +: 4])
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_in  (chain[i]),
      .step_out (chain[i+1]),
      .digit    (digits[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (chain[0].up) begin
      count_nxt = count_r + COUNT_W'(1);
    end else if (chain[0].down) begin
      count_nxt = count_r - COUNT_W'(1);
    end
  end

  // scan: pick the digit at the current position, beyond the chain it is zero
  assign place   = {1'b0, pos_r} + (POS_W+1)'(1);
  assign pos_ext = 4'(pos_r);

  always_comb begin
    cur_digit = '0;
    sel_nxt   = sel_r;
    seg_nxt   = seg_r;
    pos_nxt   = pos_r;
    if (is_scan) begin
      sel_nxt = '0;
      for (int i = 0; i < BCD_CELLS; i++) begin
        if (pos_ext == 4'(i)) begin
          cur_digit           = digits[i];
          sel_nxt[SEL_W-1-i]  = 1'b1;
        end
      end
      seg_nxt = seg_encode(cur_digit);
      pos_nxt = (place >= (POS_W+1)'(DIGITS)) ? '0 : place[POS_W-1:0];
    end
  end

  assign level = in_adc_sample[ADC_W-1:2];

  always_comb begin
    dir_nxt = dir_r;
    if (is_scan) begin
      if (level < low_r) begin
        dir_nxt = DIR_DOWN;
      end else if (level <= high_r) begin
        dir_nxt = DIR_HOLD;
      end else begin
        dir_nxt = DIR_UP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= LOW_RESET;
      high_r      <= HIGH_RESET;
      dir_r       <= DIR_HOLD;
      pos_r       <= '0;
      seg_r       <= '0;
      sel_r       <= '0;
      count_r     <= COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOW:  low_r  <= cfg_data;
          REG_HIGH: high_r <= cfg_data;
          default:  ;
        endcase
      end
      dir_r   <= dir_nxt;
      pos_r   <= pos_nxt;
      seg_r   <= seg_nxt;
      sel_r   <= sel_nxt;
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_segments     = seg_r;
  assign out_digit_select = sel_r;
  assign out_count_value  = count_r;

endmodule

>>> src/ksc_checker.sv
// ----------------------------------------------------------------------------
// ksc_checker
// port-level checks for the knob steered counter, bound to the top level
// ----------------------------------------------------------------------------
module ksc_checker import ksc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SEG_W-1:0]   out_segments,
  input logic [SEL_W-1:0]   out_digit_select,
  input logic [COUNT_W-1:0] out_count_value
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count_value)
      && $stable(out_segments) && $stable(out_digit_select))
    else $error("result word changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count_value <= COUNT_MAX)
    else $error("count outside 0..9999");

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_digit_select))
    else $error("digit select not one-hot");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // accepted word always shows up on the next cycle
  a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

endmodule

bind knob_steered_counter_with_led_scan_top ksc_checker u_ksc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_segments     (out_segments),
  .out_digit_select (out_digit_select),
  .out_count_value  (out_count_value)
);
